### hdl/chlg_pkg.sv
package chlg_pkg;

  // Window and core counts
  localparam int WINDOW_LEN = 10;
  localparam int CORE_COUNT = 4;

  // Field widths
  localparam int LOAD_W = 12;
  localparam int MASK_W = 4;
  localparam int LTHR_W = 10;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 3;
  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(CORE_COUNT + 1);
  localparam int PROD_W = LTHR_W + CNT_W;
  localparam int SUM_W  = LOAD_W + $clog2(WINDOW_LEN);

  // Divide by WINDOW_LEN as multiply by a rounded-up reciprocal and shift
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam logic [DIV_SHIFT:0] DIV_RECIP =
    (DIV_SHIFT + 1)'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [IDX_W-1:0]  RING_LAST = IDX_W'(WINDOW_LEN - 1);
  localparam logic [MASK_W-1:0] CORE_MASK = MASK_W'((1 << CORE_COUNT) - 1);
  localparam logic [MASK_W-1:0] EXTRA_MASK = 4'hC;
  localparam logic [MASK_W-1:0] NONZERO_MASK = 4'hE;
  localparam logic [CNT_W-1:0]  CORE_TOTAL = CNT_W'(CORE_COUNT);

  // Register reset values
  localparam logic [LOAD_W-1:0] ALL_ON_RST = 12'd325;
  localparam logic [LTHR_W-1:0] UP_RST     = 10'd200;
  localparam logic [LTHR_W-1:0] DOWN_RST   = 10'd125;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SUSPEND = 2'd1,
    CMD_RESUME  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ALL  = 2'd1,
    ACT_ONE  = 2'd2,
    ACT_DROP = 2'd3
  } action_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_ALL_ON = 3'd0,
    REG_UP     = 3'd1,
    REG_DOWN   = 3'd2,
    REG_QUAD   = 3'd3,
    REG_ENABLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              sampled;
    logic              quad_all;
    logic [MASK_W-1:0] online;
    logic [CNT_W-1:0]  ncores;
    logic [LOAD_W-1:0] avg;
    logic [PROD_W-1:0] up_prod;
    logic [PROD_W-1:0] dn_prod;
  } decide_in_t;

  typedef struct packed {
    action_t           action;
    logic [MASK_W-1:0] raise;
    logic [MASK_W-1:0] lower;
  } decide_out_t;

  function automatic logic [CNT_W-1:0] count_cores(logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      n = n + CNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

### hdl/chlg_decide.sv
module chlg_decide (
  input  chlg_pkg::decide_in_t       din,
  input  logic [chlg_pkg::LOAD_W-1:0] all_on_threshold,
  output chlg_pkg::decide_out_t      dout
);

  logic [chlg_pkg::MASK_W-1:0] free_cores;
  logic [chlg_pkg::MASK_W-1:0] extra;
  logic [chlg_pkg::PROD_W-1:0] avg_ext;
  logic                        can_add;

  assign free_cores = ~din.online & chlg_pkg::CORE_MASK & chlg_pkg::NONZERO_MASK;
  assign extra      = din.online & chlg_pkg::EXTRA_MASK & chlg_pkg::CORE_MASK;
  assign avg_ext    = chlg_pkg::PROD_W'(din.avg);
  assign can_add    = din.ncores < chlg_pkg::CORE_TOTAL;

  always_comb begin
    dout.action = chlg_pkg::ACT_NONE;
    dout.raise  = '0;
    dout.lower  = '0;
    case (din.cmd)
      chlg_pkg::CMD_SAMPLE: begin
        if (din.sampled) begin
          if (din.avg > all_on_threshold && can_add) begin
            dout.action = chlg_pkg::ACT_ALL;
            dout.raise  = free_cores;
          end else if (avg_ext >= din.up_prod && can_add) begin
            // lowest offline core other than core 0
            dout.action = chlg_pkg::ACT_ONE;
            dout.raise  = free_cores & (~free_cores + 4'd1);
          end else if (avg_ext < din.dn_prod && din.ncores > 3'd2) begin
            dout.action = chlg_pkg::ACT_DROP;
            dout.lower  = extra;
          end
        end
      end
      chlg_pkg::CMD_SUSPEND: begin
        if (din.ncores > 3'd1) begin
          dout.action = chlg_pkg::ACT_DROP;
          dout.lower  = extra;
        end
      end
      chlg_pkg::CMD_RESUME: begin
        if (din.quad_all) begin
          dout.action = chlg_pkg::ACT_ALL;
          dout.raise  = free_cores;
        end
      end
      default: begin
        dout.action = chlg_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

### hdl/cpu_hotplug_load_governor.sv
// Load-driven core hotplug decision block.
// Input channel (s_*): one item per sample tick, suspend or resume event.
//   s_tuser carries the command, s_tdata the load sample and online mask.
// Output channel (m_*): one result item per input item, in order: the
//   action in m_tuser, the raise and lower masks and the window average
//   in m_tdata.
// Configuration: cfg_we writes cfg_data into register cfg_index;
//   write only while no item is in flight.
// Accepted items pass stages 1 to 3 and the output register. Throughput is one
//   item per cycle while the receiver takes results: the ring memory is read at
//   accept and written back from stage 1, and a running sum keeps the window total.
// The divide by the window length is a reciprocal multiply in its own stage.
// Reset clears the ring (through per-entry valid bits), the ring index, the
//   sum, the suspend flag and the configuration registers to their
//   defaults; no clearing pass is needed, so items are taken right after reset.
// When the receiver stalls, the whole pipeline holds and s_tready drops
//   while a result waits un-taken in the output register.
module cpu_hotplug_load_governor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // load_sample[11:0], online_mask[15:12]
  input  logic [1:0]                   s_tuser,   // command[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // raise_mask[3:0], lower_mask[7:4],
                                                  // window_average[19:8], zero[23:20]
  output logic [1:0]                   m_tuser,   // action[1:0]
  input  logic                         cfg_we,
  input  logic [chlg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [chlg_pkg::CFG_W-1:0]   cfg_data
);

  // Configuration registers
  logic [chlg_pkg::LOAD_W-1:0] all_on_threshold;
  logic [chlg_pkg::LTHR_W-1:0] up_threshold;
  logic [chlg_pkg::LTHR_W-1:0] down_threshold;
  logic                        quad_mode;
  logic                        governor_enable;

  // Ring memory and control state
  logic [chlg_pkg::LOAD_W-1:0] ring_mem [chlg_pkg::WINDOW_LEN];
  logic [chlg_pkg::WINDOW_LEN-1:0] ring_vld;
  logic [chlg_pkg::IDX_W-1:0]  ring_index;
  logic [chlg_pkg::SUM_W-1:0]  window_sum;
  logic                        suspended;
  logic [chlg_pkg::LOAD_W-1:0] rd_data;
  logic                        rd_vld;

  // Pipeline
  logic                        adv;
  logic                        acc;
  chlg_pkg::cmd_t              in_cmd;
  logic [chlg_pkg::MASK_W-1:0] in_online;
  logic                        in_sampled;

  logic                        s1_v;
  chlg_pkg::cmd_t              s1_cmd;
  logic                        s1_samp;
  logic                        s1_quad_all;
  logic [chlg_pkg::MASK_W-1:0] s1_online;
  logic [chlg_pkg::CNT_W-1:0]  s1_ncores;
  logic [chlg_pkg::LOAD_W-1:0] s1_sample;
  logic [chlg_pkg::IDX_W-1:0]  s1_addr;
  logic [chlg_pkg::LOAD_W-1:0] s1_old;
  logic [chlg_pkg::SUM_W-1:0]  sum_next;

  logic                        s2_v;
  chlg_pkg::cmd_t              s2_cmd;
  logic                        s2_samp;
  logic                        s2_quad_all;
  logic [chlg_pkg::MASK_W-1:0] s2_online;
  logic [chlg_pkg::CNT_W-1:0]  s2_ncores;
  logic [chlg_pkg::SUM_W-1:0]  s2_sum;
  logic [chlg_pkg::SUM_W+chlg_pkg::DIV_SHIFT:0] avg_prod;

  logic                        s3_v;
  chlg_pkg::decide_in_t        s3_din;
  chlg_pkg::decide_out_t       s3_dout;

  logic [chlg_pkg::LOAD_W-1:0] out_avg;
  chlg_pkg::decide_out_t       out_res;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign acc      = s_tvalid && s_tready;

  assign in_cmd     = chlg_pkg::cmd_t'(s_tuser);
  assign in_online  = s_tdata[15:12] & chlg_pkg::CORE_MASK;
  assign in_sampled = (in_cmd == chlg_pkg::CMD_SAMPLE) && !suspended && governor_enable;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      all_on_threshold <= chlg_pkg::ALL_ON_RST;
      up_threshold     <= chlg_pkg::UP_RST;
      down_threshold   <= chlg_pkg::DOWN_RST;
      quad_mode        <= 1'b0;
      governor_enable  <= 1'b1;
    end else if (cfg_we) begin
      case (chlg_pkg::reg_idx_t'(cfg_index))
        chlg_pkg::REG_ALL_ON: all_on_threshold <= cfg_data;
        chlg_pkg::REG_UP:     up_threshold     <= cfg_data[chlg_pkg::LTHR_W-1:0];
        chlg_pkg::REG_DOWN:   down_threshold   <= cfg_data[chlg_pkg::LTHR_W-1:0];
        chlg_pkg::REG_QUAD:   quad_mode        <= cfg_data[0];
        chlg_pkg::REG_ENABLE: governor_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Control state updated at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
      suspended  <= 1'b0;
    end else if (acc) begin
      if (in_sampled) begin
        ring_index <= (ring_index == chlg_pkg::RING_LAST) ? '0 : ring_index + 1'b1;
      end
      if (in_cmd == chlg_pkg::CMD_SUSPEND) begin
        suspended <= 1'b1;
      end else if (in_cmd == chlg_pkg::CMD_RESUME) begin
        suspended <= 1'b0;
      end
    end
  end

  // Ring memory: read at accept, write back from stage 1. The entry written
  // by stage 1 is always the one before ring_index, so no forwarding needed.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= ring_mem[ring_index];
    end
    if (adv && s1_v && s1_samp) begin
      ring_mem[s1_addr] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      rd_vld   <= 1'b0;
    end else if (adv) begin
      rd_vld <= ring_vld[ring_index];
      if (s1_v && s1_samp) begin
        ring_vld[s1_addr] <= 1'b1;
      end
    end
  end

  // Stage 1: running sum
  assign s1_old   = rd_vld ? rd_data : '0;
  assign sum_next = window_sum - chlg_pkg::SUM_W'(s1_old) + chlg_pkg::SUM_W'(s1_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (adv && s1_v && s1_samp) begin
      window_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_v <= acc;
      s2_v <= s1_v;
      s3_v <= s2_v;
      m_tvalid <= s3_v;
    end
  end

  // Payload registers
  assign avg_prod = (chlg_pkg::SUM_W + chlg_pkg::DIV_SHIFT + 1)'(s2_sum)
                  * (chlg_pkg::SUM_W + chlg_pkg::DIV_SHIFT + 1)'(chlg_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd      <= in_cmd;
      s1_samp     <= in_sampled;
      s1_quad_all <= !governor_enable && quad_mode;
      s1_online   <= in_online;
      s1_ncores   <= chlg_pkg::count_cores(in_online);
      s1_sample   <= s_tdata[11:0];
      s1_addr     <= ring_index;

      s2_cmd      <= s1_cmd;
      s2_samp     <= s1_samp;
      s2_quad_all <= s1_quad_all;
      s2_online   <= s1_online;
      s2_ncores   <= s1_ncores;
      s2_sum      <= s1_samp ? sum_next : window_sum;

      s3_din.cmd      <= s2_cmd;
      s3_din.sampled  <= s2_samp;
      s3_din.quad_all <= s2_quad_all;
      s3_din.online   <= s2_online;
      s3_din.ncores   <= s2_ncores;
      s3_din.avg      <= avg_prod[chlg_pkg::DIV_SHIFT +: chlg_pkg::LOAD_W];
      s3_din.up_prod  <= chlg_pkg::PROD_W'(up_threshold) * chlg_pkg::PROD_W'(s2_ncores);
      s3_din.dn_prod  <= chlg_pkg::PROD_W'(down_threshold) * chlg_pkg::PROD_W'(s2_ncores);

      out_res <= s3_dout;
      out_avg <= s3_din.avg;
    end
  end

  chlg_decide u_decide (
    .din              (s3_din),
    .all_on_threshold (all_on_threshold),
    .dout             (s3_dout)
  );

  assign m_tuser = out_res.action;
  assign m_tdata = {4'd0, out_avg, out_res.lower, out_res.raise};

`ifndef SYNTHESIS
  a_ring_index_range: assert property (@(posedge clk) disable iff (rst)
    ring_index <= chlg_pkg::RING_LAST)
    else $error("ring index out of range");

  a_masks_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.raise == '0 || out_res.lower == '0))
    else $error("raise and lower masks both set");

  a_core_zero_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.raise[0] == 1'b0 && out_res.lower[0] == 1'b0))
    else $error("core zero raised or lowered");

  a_none_no_masks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.action == chlg_pkg::ACT_NONE)
      |-> (out_res.raise == '0 && out_res.lower == '0))
    else $error("masks set without an action");

  a_sum_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    !(adv && s1_v && s1_samp) |=> $stable(window_sum))
    else $error("window sum changed without a sampled item");
`endif

endmodule
